>>> src/ytrb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ytrb_pkg
// Shared types and constants for the YUV to RGB converter with overlay blend.
// ----------------------------------------------------------------------------
package ytrb_pkg;

	// APB register map
	localparam int ApbAddrW = 3;
	localparam int ApbDataW = 32;
	localparam logic [0:0] RegOutputMode = 1'b0;

	// output mode codes; the unused code behaves as blend
	typedef enum logic [1:0] {
		ModeBlend   = 2'd0,
		ModeVideo   = 2'd1,
		ModeOverlay = 2'd2
	} mode_t;

	// one pixel color
	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// overlay pixel traveling alongside the video
	typedef struct packed {
		logic [7:0] alpha;
		rgb_t       color;
	} ovl_t;

	// per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	// conversion coefficients (scaled by 100)
	localparam logic [7:0] CoefRv = 8'd140;
	localparam logic [7:0] CoefGu = 8'd34;
	localparam logic [7:0] CoefGv = 8'd71;
	localparam logic [7:0] CoefBu = 8'd177;
	localparam logic [7:0] ChromaOffset = 8'd128;

	// magnitude of a coefficient product: 177*128 fits in 15 bits
	localparam int ProdW = 15;

	// x/100 for x < 2^15 as (x*5243) >> 19
	localparam int          DivMulW  = 13;
	localparam logic [12:0] DivMul   = 13'd5243;
	localparam int          DivShift = 19;

	// signed width of y +/- two quotients
	localparam int SumW = 11;

	// blend weight width: 1..256
	localparam int WgtW = 9;
	localparam int MixW = 17;

endpackage
`default_nettype wire

>>> src/ytrb_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ytrb_ifs
// Valid/ready channels for the input pixel beat and the output pixel beat.
// ----------------------------------------------------------------------------
interface ytrb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] luma;
	logic [7:0] chroma_u;
	logic [7:0] chroma_v;
	logic [7:0] overlay_blue;
	logic [7:0] overlay_green;
	logic [7:0] overlay_red;
	logic [7:0] overlay_alpha;

	modport source (
		output valid, luma, chroma_u, chroma_v,
		output overlay_blue, overlay_green, overlay_red, overlay_alpha,
		input  ready
	);
	modport sink (
		input  valid, luma, chroma_u, chroma_v,
		input  overlay_blue, overlay_green, overlay_red, overlay_alpha,
		output ready
	);
endinterface

interface ytrb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface
`default_nettype wire

>>> src/ytrb_csc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ytrb_csc
// Three-stage YUV to RGB conversion: coefficient products, division by 100
// through a reciprocal multiply, then sign restore, sum and clamp.
// ----------------------------------------------------------------------------
module ytrb_csc (
	input  wire logic              clk,
	input  wire ytrb_pkg::pipe_en_t en,
	input  wire logic [7:0]        luma,
	input  wire logic [7:0]        chroma_u,
	input  wire logic [7:0]        chroma_v,
	input  wire ytrb_pkg::ovl_t    ovl,
	output      ytrb_pkg::rgb_t    video,
	output      ytrb_pkg::ovl_t    ovl_out
);

	localparam int PW = ytrb_pkg::ProdW;
	localparam int DW = ytrb_pkg::DivMulW;
	localparam int SW = ytrb_pkg::SumW;
	localparam int QW = PW + DW - 1;

	// chroma magnitude and sign around the 128 offset
	logic       u_neg, v_neg;
	logic [7:0] u_mag, v_mag;

	always_comb begin
		u_neg = ~chroma_u[7];
		v_neg = ~chroma_v[7];
		u_mag = u_neg ? (ytrb_pkg::ChromaOffset - chroma_u)
		              : (chroma_u - ytrb_pkg::ChromaOffset);
		v_mag = v_neg ? (ytrb_pkg::ChromaOffset - chroma_v)
		              : (chroma_v - ytrb_pkg::ChromaOffset);
	end

	// stage 1: coefficient products (magnitudes)
	logic [PW-1:0]  rv_s1, gu_s1, gv_s1, bu_s1;
	logic           u_neg_s1, v_neg_s1;
	logic [7:0]     y_s1;
	ytrb_pkg::ovl_t ovl_s1;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			rv_s1    <= PW'({8'd0, v_mag} * {8'd0, ytrb_pkg::CoefRv});
			gu_s1    <= PW'({8'd0, u_mag} * {8'd0, ytrb_pkg::CoefGu});
			gv_s1    <= PW'({8'd0, v_mag} * {8'd0, ytrb_pkg::CoefGv});
			bu_s1    <= PW'({8'd0, u_mag} * {8'd0, ytrb_pkg::CoefBu});
			u_neg_s1 <= u_neg;
			v_neg_s1 <= v_neg;
			y_s1     <= luma;
			ovl_s1   <= ovl;
		end
	end

	// divide a magnitude by 100 (truncating)
	function automatic logic [7:0] div100(input logic [PW-1:0] x);
		logic [QW-1:0] p;
		p = {{(DW-1){1'b0}}, x} * {{(PW-1){1'b0}}, ytrb_pkg::DivMul};
		return p[ytrb_pkg::DivShift +: 8];
	endfunction

	// stage 2: quotients
	logic [7:0]     rv_s2, gu_s2, gv_s2, bu_s2;
	logic           u_neg_s2, v_neg_s2;
	logic [7:0]     y_s2;
	ytrb_pkg::ovl_t ovl_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			rv_s2    <= div100(rv_s1);
			gu_s2    <= div100(gu_s1);
			gv_s2    <= div100(gv_s1);
			bu_s2    <= div100(bu_s1);
			u_neg_s2 <= u_neg_s1;
			v_neg_s2 <= v_neg_s1;
			y_s2     <= y_s1;
			ovl_s2   <= ovl_s1;
		end
	end

	// signed term from quotient magnitude
	function automatic logic signed [SW-1:0] term(input logic [7:0] q, input logic neg);
		logic signed [SW-1:0] t;
		t = $signed({{(SW-8){1'b0}}, q});
		return neg ? -t : t;
	endfunction

	function automatic logic [7:0] clamp(input logic signed [SW-1:0] s);
		logic [7:0] c;
		if (s[SW-1])
			c = 8'd0;
		else if (s[SW-2:8] != '0)
			c = 8'hFF;
		else
			c = s[7:0];
		return c;
	endfunction

	// sums before clamping
	logic signed [SW-1:0] y_ext, r_sum, g_sum, b_sum;

	always_comb begin
		y_ext = $signed({{(SW-8){1'b0}}, y_s2});
		r_sum = y_ext + term(rv_s2, v_neg_s2);
		g_sum = y_ext - term(gu_s2, u_neg_s2) - term(gv_s2, v_neg_s2);
		b_sum = y_ext + term(bu_s2, u_neg_s2);
	end

	// stage 3: clamped video color
	ytrb_pkg::rgb_t video_s3;
	ytrb_pkg::ovl_t ovl_s3;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			video_s3.r <= clamp(r_sum);
			video_s3.g <= clamp(g_sum);
			video_s3.b <= clamp(b_sum);
			ovl_s3     <= ovl_s2;
		end
	end

	assign video   = video_s3;
	assign ovl_out = ovl_s3;

endmodule
`default_nettype wire

>>> src/ytrb_blend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ytrb_blend
// Two-stage alpha blend: weighted products, then sum, shift and mode select.
// ----------------------------------------------------------------------------
module ytrb_blend (
	input  wire logic              clk,
	input  wire ytrb_pkg::pipe_en_t en,
	input  wire ytrb_pkg::mode_t   mode,
	input  wire ytrb_pkg::rgb_t    video,
	input  wire ytrb_pkg::ovl_t    ovl,
	output      ytrb_pkg::rgb_t    pixel
);

	localparam int WW = ytrb_pkg::WgtW;
	localparam int MW = ytrb_pkg::MixW;

	// weights: overlay a+1, video 256-a
	logic [WW-1:0] w_ovl, w_vid;

	always_comb begin
		w_ovl = {1'b0, ovl.alpha} + WW'(1);
		w_vid = WW'(256) - {1'b0, ovl.alpha};
	end

	function automatic logic [MW-1:0] wmul(input logic [WW-1:0] w, input logic [7:0] c);
		return {{(MW-WW){1'b0}}, w} * {{(MW-8){1'b0}}, c};
	endfunction

	// stage 4: weighted products
	logic [MW-1:0]  or_s4, og_s4, ob_s4, vr_s4, vg_s4, vb_s4;
	ytrb_pkg::rgb_t video_s4, ovl_s4;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			or_s4    <= wmul(w_ovl, ovl.color.r);
			og_s4    <= wmul(w_ovl, ovl.color.g);
			ob_s4    <= wmul(w_ovl, ovl.color.b);
			vr_s4    <= wmul(w_vid, video.r);
			vg_s4    <= wmul(w_vid, video.g);
			vb_s4    <= wmul(w_vid, video.b);
			video_s4 <= video;
			ovl_s4   <= ovl.color;
		end
	end

	// sums; result is bits 15:8
	logic [MW-1:0]  sr, sg, sb;
	ytrb_pkg::rgb_t mixed, sel;

	always_comb begin
		sr      = or_s4 + vr_s4;
		sg      = og_s4 + vg_s4;
		sb      = ob_s4 + vb_s4;
		mixed.r = sr[15:8];
		mixed.g = sg[15:8];
		mixed.b = sb[15:8];
		case (mode)
			ytrb_pkg::ModeVideo:   sel = video_s4;
			ytrb_pkg::ModeOverlay: sel = ovl_s4;
			default:               sel = mixed;
		endcase
	end

	// stage 5: output register
	ytrb_pkg::rgb_t pixel_s5;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			pixel_s5 <= sel;
		end
	end

	assign pixel = pixel_s5;

endmodule
`default_nettype wire

>>> src/yuv_to_rgb_overlay_blend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yuv_to_rgb_overlay_blend
// Converts a YUV video pixel to RGB and combines it with an overlay pixel.
// ----------------------------------------------------------------------------
// Usage:
//   px_in  : one beat per pixel (Y, U, V and overlay B, G, R, alpha).
//   px_out : one beat per pixel (R, G, B), in input order.
//   APB    : output_mode at byte address 0 (0 blend, 1 video, 2 overlay;
//            3 acts as blend). Write it only while the pipeline is empty.
// Path: each input beat passes through five registered stages to px_out
//   (products, divide by 100, clamp, blend products, blend sum and output
//   register).
// Throughput: one pixel per cycle; every stage is a single register with a
//   valid bit, so a new beat is accepted each cycle while the output moves.
// Stall: when px_out.ready is low, a full stage holds and the empty stages
//   in front of it keep filling; px_in.ready drops only when all five stages
//   hold data. Nothing is dropped or repeated.
// Reset: arst_n clears all valid bits and sets output_mode to blend.
// ----------------------------------------------------------------------------
module yuv_to_rgb_overlay_blend (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	ytrb_in_if.sink                            px_in,
	ytrb_out_if.source                         px_out,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ytrb_pkg::ApbAddrW-1:0] paddr,
	input  wire logic [ytrb_pkg::ApbDataW-1:0] pwdata,
	output      logic [ytrb_pkg::ApbDataW-1:0] prdata,
	output      logic                          pready
);

	// configuration register
	ytrb_pkg::mode_t output_mode_q;
	logic            reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[ytrb_pkg::ApbAddrW-1] == ytrb_pkg::RegOutputMode);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_mode_q <= ytrb_pkg::ModeBlend;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			output_mode_q <= ytrb_pkg::mode_t'(pwdata[1:0]);
		end
	end

	assign prdata = reg_hit ? {{(ytrb_pkg::ApbDataW-2){1'b0}}, output_mode_q} : '0;

	// stage valid bits and back-propagated ready
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	ytrb_pkg::pipe_en_t en;

	always_comb begin
		en.s5 = !v_s5 || px_out.ready;
		en.s4 = !v_s4 || en.s5;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign px_in.ready  = en.s1;
	assign px_out.valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= px_in.valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
		end
	end

	// datapath
	ytrb_pkg::ovl_t ovl_in, ovl_cv;
	ytrb_pkg::rgb_t video_cv, pixel;

	always_comb begin
		ovl_in.alpha   = px_in.overlay_alpha;
		ovl_in.color.r = px_in.overlay_red;
		ovl_in.color.g = px_in.overlay_green;
		ovl_in.color.b = px_in.overlay_blue;
	end

	ytrb_csc u_csc (
		.clk      (clk),
		.en       (en),
		.luma     (px_in.luma),
		.chroma_u (px_in.chroma_u),
		.chroma_v (px_in.chroma_v),
		.ovl      (ovl_in),
		.video    (video_cv),
		.ovl_out  (ovl_cv)
	);

	ytrb_blend u_blend (
		.clk   (clk),
		.en    (en),
		.mode  (output_mode_q),
		.video (video_cv),
		.ovl   (ovl_cv),
		.pixel (pixel)
	);

	assign px_out.out_red   = pixel.r;
	assign px_out.out_green = pixel.g;
	assign px_out.out_blue  = pixel.b;

endmodule
`default_nettype wire
